### rtl/core/spline_point_evaluator_macros.svh
// Assertion helpers shared by the spline point evaluator sources.
`ifndef SPLINE_POINT_EVALUATOR_MACROS_SVH
`define SPLINE_POINT_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("spline point evaluator assertion failed");
`define SPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spline point evaluator assertion failed");
`else
`define SPE_ASSERT(lbl, clk, rstn, prop)
`define SPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/spe_pkg.sv
package spe_pkg;

  localparam int unsigned MAX_KNOTS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned KIDX_W        = 6;
  localparam int unsigned PARAM_W       = 17;
  localparam int unsigned SEG_IDX_W     = 6;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned KCNT_W        = 7;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 7;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_BEZIER  = 2'd1,
    MODE_CATMULL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 1'b0,
    CFG_KNOT_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SEG   = 2'd1,
    ST_PAST_END = 2'd2
  } status_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KCNT_W-1:0] knot_count;
  } cfg_t;

  typedef struct packed {
    logic                      req_type;
    logic [KIDX_W-1:0]         knot_index;
    logic signed [COORD_W-1:0] knot_x;
    logic signed [COORD_W-1:0] knot_y;
    logic signed [COORD_W-1:0] knot_z;
    logic [PARAM_W-1:0]        param_t;
    logic                      whole_curve;
    logic [SEG_IDX_W-1:0]      segment_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [STATUS_W-1:0]       status;
  } out_item_t;

endpackage

### rtl/core/spline_point_evaluator.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_item_i  (in_item_t)
// out       output     out_valid_o / out_ready_i  out_item_o (out_item_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item per cycle is sustained while the output is not stalled; an evaluate
// item is accepted into the queue and then passes the address and square stage,
// weight stage, product stage and output register.
// Knot writes pass through the same queue and update the knot store in order.
// Reset is asynchronous and clears control state only; the knot store is not
// cleared. A stalled output holds the back pipeline while the two-entry queue
// keeps accepting items until it is full.
module spline_point_evaluator import spe_pkg::*; #(
  parameter int unsigned MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned T_W   = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(MAX_KNOTS + 1);
  localparam int unsigned KA_W  = $clog2(MAX_KNOTS);
  localparam int unsigned IDX_W = (CNT_W > SEG_IDX_W) ? CNT_W : SEG_IDX_W;

  typedef struct packed {
    logic                   is_write;
    logic                   wr_ok;
    logic                   no_seg;
    logic [KA_W-1:0]        waddr;
    logic [3*COORD_W-1:0]   wdata;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       segs;
    logic [IDX_W-1:0]       idx;
    logic [T_W-1:0]         t;
  } entry_t;

  logic [MODE_W-1:0] mode_q;
  logic [KCNT_W-1:0] kcnt_q;
  cfg_t              cfg;
  logic              push, q_ready, q_valid, pop;
  entry_t            push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CATMULL;
      kcnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:       mode_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_KNOT_COUNT: kcnt_q <= cfg_wdata_i[KCNT_W-1:0];
        default:        mode_q <= mode_q;
      endcase
    end
  end

  assign cfg.mode       = mode_q;
  assign cfg.knot_count = kcnt_q;

  spe_front #(
    .MAX_KNOTS(MAX_KNOTS),
    .FRAC_BITS(FRAC_BITS),
    .entry_t  (entry_t)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .cfg_i     (cfg),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  spe_queue #(
    .DEPTH  (2),
    .entry_t(entry_t)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  spe_back #(
    .MAX_KNOTS(MAX_KNOTS),
    .FRAC_BITS(FRAC_BITS),
    .entry_t  (entry_t)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .entry_i    (head_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

### rtl/core/spe_ram.sv
module spe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/spe_front.sv
module spe_front import spe_pkg::*; #(
  parameter int unsigned MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter type entry_t = logic
) (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  input  logic     q_ready_i,
  output logic     push_o,
  output entry_t   entry_o
);

  localparam int unsigned T_W   = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(MAX_KNOTS + 1);
  localparam int unsigned KA_W  = $clog2(MAX_KNOTS);
  localparam int unsigned IDX_W = (CNT_W > SEG_IDX_W) ? CNT_W : SEG_IDX_W;
  localparam int unsigned CMP_W = (CNT_W > KCNT_W) ? CNT_W : KCNT_W;
  localparam int unsigned P_W   = T_W + CNT_W;
  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [CMP_W-1:0] kc;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] segs;
  logic [T_W-1:0]   t_raw;
  logic [T_W-1:0]   t_cl;
  logic [P_W-1:0]   prod;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    kc  = CMP_W'(cfg_i.knot_count);
    cnt = (kc > CMP_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : CNT_W'(kc);
    segs = '0;
    if (cfg_i.mode == MODE_LINEAR || cfg_i.mode == MODE_CATMULL) begin
      if (cnt >= CNT_W'(2)) begin
        segs = cnt - CNT_W'(1);
      end
    end else if (cfg_i.mode == MODE_BEZIER) begin
      if (cnt >= CNT_W'(4) && cnt[1:0] == 2'b00) begin
        segs = cnt >> 2;
      end
    end
    t_raw = T_W'(in_item_i.param_t);
    t_cl  = (t_raw > T_ONE) ? T_ONE : t_raw;
    prod  = P_W'(t_cl) * P_W'(segs);

    entry_o.is_write = (in_item_i.req_type == REQ_WRITE);
    entry_o.wr_ok    = (32'(in_item_i.knot_index) < MAX_KNOTS);
    entry_o.no_seg   = (segs == '0);
    entry_o.waddr    = KA_W'(in_item_i.knot_index);
    entry_o.wdata    = {in_item_i.knot_z, in_item_i.knot_y, in_item_i.knot_x};
    entry_o.cnt      = cnt;
    entry_o.segs     = segs;
    if (in_item_i.whole_curve) begin
      entry_o.idx = IDX_W'(prod >> FRAC_BITS);
      entry_o.t   = T_W'(prod[FRAC_BITS-1:0]);
    end else begin
      entry_o.idx = IDX_W'(in_item_i.segment_index);
      entry_o.t   = t_cl;
    end
  end

endmodule

### rtl/core/spe_queue.sv
`include "spline_point_evaluator_macros.svh"

module spe_queue import spe_pkg::*; #(
  parameter int unsigned DEPTH = 2,
  parameter type entry_t = logic
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `SPE_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH))
  `SPE_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != '0)

endmodule

### rtl/core/spe_back.sv
`include "spline_point_evaluator_macros.svh"

module spe_back import spe_pkg::*; #(
  parameter int unsigned MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter type entry_t = logic
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  entry_t    entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned T_W   = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(MAX_KNOTS + 1);
  localparam int unsigned KA_W  = $clog2(MAX_KNOTS);
  localparam int unsigned IDX_W = (CNT_W > SEG_IDX_W) ? CNT_W : SEG_IDX_W;
  localparam int unsigned IW2   = IDX_W + 2;
  localparam int unsigned M_W   = 2 * T_W + 2;
  localparam int unsigned WW    = T_W + 4;
  localparam int unsigned PW    = COORD_W + WW;
  localparam int unsigned AW    = PW + 2;
  localparam int unsigned RW    = 3 * COORD_W;
  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [M_W-1:0] U_HALF = M_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] R_HALF  = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] R_ONE   = AW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0] SAT_MAX = AW'(32'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] SAT_MIN = AW'(32'sh8000_0000);

  function automatic logic [T_W-1:0] rnd_u(input logic [M_W-1:0] a);
    logic [M_W-1:0] s;
    s = a + U_HALF;
    return T_W'(s >> FRAC_BITS);
  endfunction

  function automatic logic [KA_W-1:0] clampk(input logic [IW2-1:0] v);
    return (32'(v) < MAX_KNOTS) ? KA_W'(v) : KA_W'(MAX_KNOTS - 1);
  endfunction

  function automatic logic signed [WW-1:0] ext(input logic [T_W-1:0] v);
    return $signed(WW'(v));
  endfunction

  logic adv;
  logic pop;
  logic ram_we;

  // Stage A: classify, addresses, squares.
  logic                past;
  logic [IW2-1:0]      i0;
  logic [IW2-1:0]      ki [4];
  logic [KA_W-1:0]     raddr [4];
  logic [RW-1:0]       rdata [4];
  logic [T_W-1:0]      t_a, s_a;
  logic                a_vld_q, a_zero_q;
  logic [STATUS_W-1:0] a_status_q;
  logic [MODE_W-1:0]   a_mode_q;
  logic [T_W-1:0]      a_t_q, a_s_q, a_t2_q, a_s2_q;

  // Stage B: weights.
  logic [T_W-1:0]         t3, w_s2s, w_ts2, w_t2s;
  logic signed [WW-1:0]   w_d [4];
  logic                   b_vld_q, b_zero_q, b_cr_q;
  logic [STATUS_W-1:0]    b_status_q;
  logic signed [WW-1:0]   b_w_q [4];
  logic [RW-1:0]          b_data_q [4];

  // Stage C: products.
  logic                   c_vld_q, c_zero_q, c_cr_q;
  logic [STATUS_W-1:0]    c_status_q;
  logic signed [PW-1:0]   c_prod_q [4][3];

  // Output stage.
  logic signed [AW-1:0]      acc [3];
  logic signed [AW-1:0]      rsh [3];
  logic signed [COORD_W-1:0] pt  [3];
  logic                      out_vld_q;
  out_item_t                 out_q, out_d;

  assign adv    = !out_vld_q || out_ready_i;
  assign pop    = adv && q_valid_i;
  assign pop_o  = pop;
  assign ram_we = pop && entry_i.is_write && entry_i.wr_ok;

  always_comb begin
    past = (entry_i.idx >= IDX_W'(entry_i.segs));
    i0   = IW2'(entry_i.idx);
    if (past) begin
      for (int k = 0; k < 4; k++) begin
        ki[k] = IW2'(entry_i.cnt) - IW2'(1);
      end
    end else if (cfg_i.mode == MODE_LINEAR) begin
      ki[0] = i0;
      ki[1] = i0 + IW2'(1);
      ki[2] = i0;
      ki[3] = i0;
    end else if (cfg_i.mode == MODE_BEZIER) begin
      for (int k = 0; k < 4; k++) begin
        ki[k] = (i0 << 2) + IW2'(k);
      end
    end else begin
      ki[0] = (i0 != '0) ? i0 - IW2'(1) : i0;
      ki[1] = i0;
      ki[2] = i0 + IW2'(1);
      ki[3] = (i0 + IW2'(2) < IW2'(entry_i.cnt)) ? i0 + IW2'(2) : i0 + IW2'(1);
    end
    for (int k = 0; k < 4; k++) begin
      raddr[k] = clampk(ki[k]);
    end
    t_a = past ? '0 : entry_i.t;
    s_a = T_ONE - t_a;
  end

  for (genvar k = 0; k < 4; k++) begin : g_ram
    spe_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_KNOTS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(entry_i.waddr),
      .wdata_i(entry_i.wdata),
      .re_i   (adv),
      .raddr_i(raddr[k]),
      .rdata_o(rdata[k])
    );
  end

  always_comb begin
    t3    = rnd_u(M_W'(a_t2_q) * M_W'(a_t_q));
    w_s2s = rnd_u(M_W'(a_s2_q) * M_W'(a_s_q));
    w_ts2 = rnd_u(M_W'(3) * M_W'(a_t_q) * M_W'(a_s2_q));
    w_t2s = rnd_u(M_W'(3) * M_W'(a_t2_q) * M_W'(a_s_q));
    if (a_mode_q == MODE_LINEAR) begin
      w_d[0] = ext(a_s_q);
      w_d[1] = ext(a_t_q);
      w_d[2] = '0;
      w_d[3] = '0;
    end else if (a_mode_q == MODE_BEZIER) begin
      w_d[0] = ext(w_s2s);
      w_d[1] = ext(w_ts2);
      w_d[2] = ext(w_t2s);
      w_d[3] = ext(t3);
    end else begin
      w_d[0] = (ext(a_t2_q) <<< 1) - ext(t3) - ext(a_t_q);
      w_d[1] = (ext(t3) <<< 1) + ext(t3) - (ext(a_t2_q) <<< 2) - ext(a_t2_q)
               + (ext(T_ONE) <<< 1);
      w_d[2] = (ext(a_t2_q) <<< 2) - (ext(t3) <<< 1) - ext(t3) + ext(a_t_q);
      w_d[3] = ext(t3) - ext(a_t2_q);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AW'(c_prod_q[0][c]) + AW'(c_prod_q[1][c])
             + AW'(c_prod_q[2][c]) + AW'(c_prod_q[3][c]);
      if (c_cr_q) begin
        rsh[c] = (acc[c] + R_ONE) >>> (FRAC_BITS + 1);
      end else begin
        rsh[c] = (acc[c] + R_HALF) >>> FRAC_BITS;
      end
      if (c_zero_q) begin
        pt[c] = '0;
      end else if (rsh[c] > SAT_MAX) begin
        pt[c] = SAT_MAX[COORD_W-1:0];
      end else if (rsh[c] < SAT_MIN) begin
        pt[c] = SAT_MIN[COORD_W-1:0];
      end else begin
        pt[c] = rsh[c][COORD_W-1:0];
      end
    end
    out_d.point_x = pt[0];
    out_d.point_y = pt[1];
    out_d.point_z = pt[2];
    out_d.status  = c_status_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_zero_q <= entry_i.is_write || entry_i.no_seg;
      if (entry_i.is_write) begin
        a_status_q <= ST_OK;
      end else if (entry_i.no_seg) begin
        a_status_q <= ST_NO_SEG;
      end else if (past) begin
        a_status_q <= ST_PAST_END;
      end else begin
        a_status_q <= ST_OK;
      end
      a_mode_q <= past ? MODE_LINEAR : cfg_i.mode;
      a_t_q    <= t_a;
      a_s_q    <= s_a;
      a_t2_q   <= rnd_u(M_W'(t_a) * M_W'(t_a));
      a_s2_q   <= rnd_u(M_W'(s_a) * M_W'(s_a));

      b_zero_q   <= a_zero_q;
      b_status_q <= a_status_q;
      b_cr_q     <= (a_mode_q == MODE_CATMULL);
      for (int k = 0; k < 4; k++) begin
        b_w_q[k]    <= w_d[k];
        b_data_q[k] <= rdata[k];
      end

      c_zero_q   <= b_zero_q;
      c_status_q <= b_status_q;
      c_cr_q     <= b_cr_q;
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          c_prod_q[k][c] <= PW'($signed(b_data_q[k][c*COORD_W +: COORD_W])) * PW'(b_w_q[k]);
        end
      end

      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= q_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      out_vld_q <= c_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  `SPE_ASSERT_IMPL(a_ram_we_adv, clk_i, rst_ni, ram_we, adv && q_valid_i)
  `SPE_ASSERT_IMPL(a_noseg_zero, clk_i, rst_ni, out_vld_q && (out_q.status == ST_NO_SEG), out_q.point_x == '0 && out_q.point_y == '0 && out_q.point_z == '0)
  `SPE_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_vld_q && !out_ready_i, !pop)

endmodule

### tb/tb_spline_point_evaluator.sv
`timescale 1ns / 1ps

module tb_spline_point_evaluator;
  import spe_pkg::*;

  localparam longint TONE = 64'sd1 << FRAC_BITS_DEF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  spline_point_evaluator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: knot store and register copies.
  logic signed [COORD_W-1:0] knot_x_mem [MAX_KNOTS_DEF];
  logic signed [COORD_W-1:0] knot_y_mem [MAX_KNOTS_DEF];
  logic signed [COORD_W-1:0] knot_z_mem [MAX_KNOTS_DEF];
  logic [MODE_W-1:0]         curve_mode = MODE_CATMULL;
  logic [KCNT_W-1:0]         knots_in_use = '0;

  in_item_t  pending_items [$];
  out_item_t expected_points [$];
  int        mismatches = 0;
  bit        hold_off = 1'b0;

  // Stimulus-side view of the mode, count and which knots are written.
  logic [MODE_W-1:0] gen_mode = MODE_CATMULL;
  int                gen_count = 0;
  bit                gen_written [MAX_KNOTS_DEF];

  function automatic longint seg_total(logic [MODE_W-1:0] m, longint cnt);
    if (m == MODE_LINEAR || m == MODE_CATMULL) return cnt < 2 ? 0 : cnt - 1;
    if (m == MODE_BEZIER) return (cnt < 4 || cnt % 4 != 0) ? 0 : cnt / 4;
    return 0;
  endfunction

  function automatic longint round_frac(longint acc, int sh);
    return (acc + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [COORD_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_item_t predict_point(in_item_t it);
    out_item_t r;
    longint    cnt, segs, idx, t, s, t2, t3, s2, p, acc, val;
    longint    w [4];
    longint    ki [4];
    int        sh;
    r = '0;
    sh = FRAC_BITS_DEF;
    if (it.req_type == REQ_WRITE) begin
      knot_x_mem[it.knot_index] = it.knot_x;
      knot_y_mem[it.knot_index] = it.knot_y;
      knot_z_mem[it.knot_index] = it.knot_z;
      r.status = ST_OK;
      return r;
    end
    cnt = knots_in_use > MAX_KNOTS_DEF ? MAX_KNOTS_DEF : knots_in_use;
    segs = seg_total(curve_mode, cnt);
    if (segs == 0) begin
      r.status = ST_NO_SEG;
      return r;
    end
    t = it.param_t;
    if (t > TONE) t = TONE;
    if (it.whole_curve) begin
      p = t * segs;
      idx = p >>> FRAC_BITS_DEF;
      t = p & (TONE - 1);
    end else begin
      idx = it.segment_index;
    end
    if (idx >= segs) begin
      r.point_x = knot_x_mem[cnt-1];
      r.point_y = knot_y_mem[cnt-1];
      r.point_z = knot_z_mem[cnt-1];
      r.status  = ST_PAST_END;
      return r;
    end
    if (curve_mode == MODE_LINEAR) begin
      ki = '{idx, idx + 1, idx, idx};
      w  = '{TONE - t, t, 0, 0};
    end else if (curve_mode == MODE_BEZIER) begin
      s  = TONE - t;
      t2 = round_frac(t * t, FRAC_BITS_DEF);
      s2 = round_frac(s * s, FRAC_BITS_DEF);
      ki = '{idx * 4, idx * 4 + 1, idx * 4 + 2, idx * 4 + 3};
      w[0] = round_frac(s2 * s, FRAC_BITS_DEF);
      w[1] = round_frac(3 * t * s2, FRAC_BITS_DEF);
      w[2] = round_frac(3 * t2 * s, FRAC_BITS_DEF);
      w[3] = round_frac(t2 * t, FRAC_BITS_DEF);
    end else begin
      t2 = round_frac(t * t, FRAC_BITS_DEF);
      t3 = round_frac(t2 * t, FRAC_BITS_DEF);
      ki[0] = idx > 0 ? idx - 1 : idx;
      ki[1] = idx;
      ki[2] = idx + 1;
      ki[3] = idx + 2 < cnt ? idx + 2 : idx + 1;
      w[0] = -t3 + 2 * t2 - t;
      w[1] = 3 * t3 - 5 * t2 + 2 * TONE;
      w[2] = -3 * t3 + 4 * t2 + t;
      w[3] = t3 - t2;
      sh = FRAC_BITS_DEF + 1;
    end
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        val = c == 0 ? knot_x_mem[ki[k]]
                     : (c == 1 ? knot_y_mem[ki[k]] : knot_z_mem[ki[k]]);
        acc += val * w[k];
      end
      if (c == 0) r.point_x = clip32(round_frac(acc, sh));
      else if (c == 1) r.point_y = clip32(round_frac(acc, sh));
      else r.point_z = clip32(round_frac(acc, sh));
    end
    r.status = ST_OK;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_points = {expected_points, predict_point(in_item)};
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_item  <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is redrawn when pattern_age runs out; long holds on request.
  int ready_pattern = 0;
  int pattern_age = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item);
        end else begin
          want = expected_points.pop_front();
          if (out_item.point_x !== want.point_x || out_item.point_y !== want.point_y ||
              out_item.point_z !== want.point_z || out_item.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                       want.point_x, want.point_y, want.point_z, want.status,
                       out_item.point_x, out_item.point_y, out_item.point_z,
                       out_item.status);
          end
        end
      end
      if (pattern_age >= 50) begin
        pattern_age   <= 0;
        ready_pattern <= $urandom_range(0, 3);
      end else begin
        pattern_age <= pattern_age + 1;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        case (ready_pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= $urandom_range(0, 7) != 0;
          default: out_ready <= pattern_age % 3 != 0;
        endcase
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 8'hFF) << 16)) - 32'sd8388608;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_write(int idx, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    in_item_t it;
    it = '0;
    it.req_type      = REQ_WRITE;
    it.knot_index    = KIDX_W'(idx);
    it.knot_x        = x;
    it.knot_y        = y;
    it.knot_z        = z;
    it.param_t       = PARAM_W'($urandom);
    it.whole_curve   = 1'($urandom);
    it.segment_index = SEG_IDX_W'($urandom);
    gen_written[idx] = 1'b1;
    pending_items = {pending_items, it};
  endtask

  task automatic push_eval(longint t, bit whole, int seg);
    in_item_t it;
    int       lim;
    lim = gen_count > MAX_KNOTS_DEF ? MAX_KNOTS_DEF : gen_count;
    for (int i = 0; i < lim; i++)
      if (!gen_written[i]) push_write(i, pick_coord(), pick_coord(), pick_coord());
    it = '0;
    it.req_type      = REQ_EVAL;
    it.knot_index    = KIDX_W'($urandom);
    it.knot_x        = $urandom;
    it.knot_y        = $urandom;
    it.knot_z        = $urandom;
    it.param_t       = PARAM_W'(t);
    it.whole_curve   = whole;
    it.segment_index = SEG_IDX_W'(seg);
    pending_items = {pending_items, it};
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    if (idx == CFG_MODE) curve_mode = v[MODE_W-1:0];
    else knots_in_use = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_curve(int m, int cnt);
    wait_idle();
    repeat (10) @(posedge clk_i);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_KNOT_COUNT, CFG_DATA_W'(cnt));
    gen_mode  = MODE_W'(m);
    gen_count = cnt;
  endtask

  task automatic push_random_item();
    longint t;
    int     segs;
    if ($urandom_range(0, 3) == 0) begin
      push_write($urandom_range(0, 63), pick_coord(), pick_coord(), pick_coord());
    end else begin
      case ($urandom_range(0, 9))
        0: t = 0;
        1: t = TONE;
        2: t = $urandom_range(32'(TONE + 1), 131071);
        3: t = $urandom_range(0, 1) ? 1 : TONE - 1;
        default: t = $urandom_range(0, 32'(TONE));
      endcase
      segs = int'(seg_total(gen_mode, gen_count > 64 ? 64 : gen_count));
      push_eval(t, 1'($urandom_range(0, 1)),
                $urandom_range(0, 4) == 0 ? $urandom_range(0, 63)
                                          : $urandom_range(0, segs + 1 > 63 ? 63 : segs + 1));
    end
  endtask

  localparam int NPHASE = 14;
  int phase_mode [NPHASE] = '{0, 1, 2, 2, 1, 0, 0, 1, 2, 0, 1, 2, 0, 1};
  int phase_cnt  [NPHASE] = '{2, 4, 2, 3, 5, 1, 0, 64, 64, 64, 8, 17, 33, 0};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no segments at reset, extremes, clamping, past end, each mode.
    push_eval(TONE / 2, 1'b0, 0);
    set_curve(MODE_LINEAR, 2);
    push_write(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
    push_write(1, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1);
    push_eval(0, 1'b0, 0);
    push_eval(TONE, 1'b0, 0);
    push_eval(131071, 1'b0, 0);
    push_eval(TONE / 2, 1'b1, 0);
    push_eval(TONE, 1'b1, 0);
    push_eval(12345, 1'b0, 63);
    set_curve(MODE_CATMULL, 2);
    push_eval(TONE / 3, 1'b0, 0);
    push_eval(TONE, 1'b1, 5);
    set_curve(MODE_BEZIER, 4);
    push_write(2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    push_write(3, 32'sh80000000, 32'sh0, 32'sh7FFFFFFF);
    push_eval(40000, 1'b1, 0);
    push_eval(TONE / 2, 1'b0, 1);
    set_curve(MODE_BEZIER, 5);
    push_eval(TONE / 2, 1'b0, 0);
    set_curve(MODE_CATMULL, 4);
    push_write(1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_write(2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    push_eval(TONE / 2, 1'b0, 1);
    push_eval(TONE / 4, 1'b0, 0);

    for (int ph = 0; ph < NPHASE; ph++) begin
      set_curve(phase_mode[ph], phase_cnt[ph]);
      if (ph == 8) begin
        fork
          begin
            @(negedge clk_i);
            hold_off = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (60) push_random_item();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/spe_pkg.sv
rtl/core/spe_ram.sv
rtl/core/spe_front.sv
rtl/core/spe_queue.sv
rtl/core/spe_back.sv
rtl/core/spline_point_evaluator.sv
tb/tb_spline_point_evaluator.sv
